### rtl/dequ_pkg.sv
// Shared constants, codes and types for the double-ended queue unit.
package dequ_pkg;

  localparam int unsigned DEPTH  = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned STAT_W = 2;

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_REAR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LIST      = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_R,
    CELL_SHIFT_L,
    CELL_WRITE,
    CELL_ROTATE
  } cell_op_e;

  // Broadcast to every cell of the row each cycle
  typedef struct packed {
    cell_op_e          op;
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  count;
  } cell_ctrl_t;

endpackage

### rtl/dequ_cell.sv
// One storage cell of the queue row: holds one entry and trades it with its neighbours.
module dequ_cell (
  input  logic                        clk_i,
  input  dequ_pkg::cell_ctrl_t        ctrl_i,
  input  logic [dequ_pkg::IDX_W-1:0]  idx_i,
  input  logic [dequ_pkg::DATA_W-1:0] left_i,
  input  logic [dequ_pkg::DATA_W-1:0] right_i,
  input  logic [dequ_pkg::DATA_W-1:0] head_i,
  output logic [dequ_pkg::DATA_W-1:0] value_o,
  output logic [dequ_pkg::DATA_W-1:0] tap_o
);

  logic [dequ_pkg::DATA_W-1:0] value_q, value_d;
  logic [dequ_pkg::CNT_W-1:0]  idx_ext;
  logic                        is_next;
  logic                        is_tail;

  assign idx_ext = dequ_pkg::CNT_W'(idx_i);
  assign is_next = (idx_ext == ctrl_i.count);
  assign is_tail = (idx_ext == ctrl_i.count - dequ_pkg::CNT_W'(1));

  always_comb begin
    value_d = value_q;
    case (ctrl_i.op)
      dequ_pkg::CELL_HOLD:    value_d = value_q;
      dequ_pkg::CELL_SHIFT_R: value_d = left_i;
      dequ_pkg::CELL_SHIFT_L: value_d = right_i;
      dequ_pkg::CELL_WRITE:   value_d = is_next ? ctrl_i.value : value_q;
      // tail wraps round to the old head, so a full lap restores the row
      dequ_pkg::CELL_ROTATE:  value_d = is_tail ? head_i : right_i;
      default:                value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign tap_o   = is_tail ? value_q : '0;

endmodule

### rtl/double_ended_queue_unit.sv
// Double-ended queue unit: top level with command control and the row of cells.
// Entries sit in a row of cells with the front in cell 0. Insert and delete
// commands take one beat each and answer with a single result beat in the
// following cycle; a new command is taken every cycle while the output register drains.
// A list command walks the row by rotating it one cell per cycle while the
// output register is free, returning each stored entry (up to 32) front first,
// and no command is accepted until the last listed entry has been registered.
// Commands 5 to 7 are consumed with no result.
module double_ended_queue_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  output logic                        s_tready_o,
  input  logic [dequ_pkg::DATA_W-1:0] s_tdata_i,  // [31:0] value
  input  logic [dequ_pkg::CMD_W-1:0]  s_tuser_i,  // [2:0] command
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [dequ_pkg::DATA_W-1:0] m_tdata_o,  // [31:0] value_res
  output logic [dequ_pkg::STAT_W-1:0] m_tuser_o,  // [1:0] status
  output logic                        m_tlast_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LIST = 1'b1;

  logic state_q, state_d;
  logic [dequ_pkg::CNT_W-1:0]  count_q, count_d;
  logic [dequ_pkg::CNT_W-1:0]  remain_q, remain_d;
  logic                        m_valid_q, m_valid_d;
  logic [dequ_pkg::DATA_W-1:0] m_data_q, m_data_d;
  logic [dequ_pkg::STAT_W-1:0] m_stat_q, m_stat_d;
  logic                        m_last_q, m_last_d;

  logic out_free;
  logic accept;
  logic is_full;
  logic is_empty;

  dequ_pkg::cell_ctrl_t        ctrl;
  logic [dequ_pkg::DATA_W-1:0] cell_val [dequ_pkg::DEPTH];
  logic [dequ_pkg::DATA_W-1:0] cell_tap [dequ_pkg::DEPTH];
  logic [dequ_pkg::DATA_W-1:0] tail_val;

  assign out_free   = !m_valid_q || m_tready_i;
  assign s_tready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = s_tvalid_i && s_tready_o;
  assign is_full    = (count_q == dequ_pkg::CNT_W'(dequ_pkg::DEPTH));
  assign is_empty   = (count_q == '0);

  // rear entry: each cell gates itself onto the bus when it is the tail
  always_comb begin
    tail_val = '0;
    for (int k = 0; k < int'(dequ_pkg::DEPTH); k++) begin
      tail_val = tail_val | cell_tap[k];
    end
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    remain_d   = remain_q;
    m_valid_d  = m_valid_q && !m_tready_i;
    m_data_d   = m_data_q;
    m_stat_d   = m_stat_q;
    m_last_d   = m_last_q;
    ctrl.op    = dequ_pkg::CELL_HOLD;
    ctrl.value = s_tdata_i;
    ctrl.count = count_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          m_data_d = '0;
          m_stat_d = dequ_pkg::STAT_OK;
          m_last_d = 1'b1;
          case (s_tuser_i)
            dequ_pkg::CMD_INS_FRONT, dequ_pkg::CMD_INS_REAR: begin
              m_valid_d = 1'b1;
              if (is_full) begin
                m_stat_d = dequ_pkg::STAT_FULL;
              end else begin
                ctrl.op = (s_tuser_i == dequ_pkg::CMD_INS_FRONT) ?
                          dequ_pkg::CELL_SHIFT_R : dequ_pkg::CELL_WRITE;
                count_d = count_q + dequ_pkg::CNT_W'(1);
              end
            end
            dequ_pkg::CMD_DEL_FRONT, dequ_pkg::CMD_DEL_REAR: begin
              m_valid_d = 1'b1;
              if (is_empty) begin
                m_stat_d = dequ_pkg::STAT_EMPTY;
              end else begin
                if (s_tuser_i == dequ_pkg::CMD_DEL_FRONT) begin
                  m_data_d = cell_val[0];
                  ctrl.op  = dequ_pkg::CELL_SHIFT_L;
                end else begin
                  m_data_d = tail_val;
                end
                count_d = count_q - dequ_pkg::CNT_W'(1);
              end
            end
            dequ_pkg::CMD_LIST: begin
              if (is_empty) begin
                m_valid_d = 1'b1;
                m_stat_d  = dequ_pkg::STAT_EMPTY;
              end else begin
                state_d  = ST_LIST;
                remain_d = count_q;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LIST: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = cell_val[0];
          m_stat_d  = dequ_pkg::STAT_OK;
          m_last_d  = (remain_q == dequ_pkg::CNT_W'(1));
          ctrl.op   = dequ_pkg::CELL_ROTATE;
          remain_d  = remain_q - dequ_pkg::CNT_W'(1);
          if (remain_q == dequ_pkg::CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  for (genvar g = 0; g < int'(dequ_pkg::DEPTH); g++) begin : g_cell
    logic [dequ_pkg::DATA_W-1:0] left_v;
    logic [dequ_pkg::DATA_W-1:0] right_v;

    if (g == 0) begin : g_first
      assign left_v = s_tdata_i;
    end else begin : g_mid_l
      assign left_v = cell_val[g-1];
    end

    if (g == int'(dequ_pkg::DEPTH) - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[g+1];
    end

    dequ_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (dequ_pkg::IDX_W'(g)),
      .left_i  (left_v),
      .right_i (right_v),
      .head_i  (cell_val[0]),
      .value_o (cell_val[g]),
      .tap_o   (cell_tap[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      remain_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      remain_q  <= remain_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_stat_q <= m_stat_d;
    m_last_q <= m_last_d;
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tuser_o  = m_stat_q;
  assign m_tlast_o  = m_last_q;

endmodule
